FILE: rtl/sgk_pkg.sv
// Shared types and constants for the spike-gated scalar Kalman filter.
// Holds the controller state type, the command and status bundles and register indexes.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package sgk_pkg;

	localparam int ANGLE_W = 25;
	localparam int REG_W   = 24;
	localparam int EST_W   = 32;
	localparam int COV_W   = 25;
	localparam int ADDR_W  = 2;

	localparam logic [ADDR_W-1:0] REG_PROCESS_NOISE     = 2'd0;
	localparam logic [ADDR_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
	localparam logic [ADDR_W-1:0] REG_SPIKE_LIMIT       = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GATE,
		ST_PREP,
		ST_DIV,
		ST_MUL_LOAD,
		ST_MUL,
		ST_WB
	} sgk_state_t;

	typedef struct packed {
		logic load;
		logic gate;
		logic prep;
		logic div_step;
		logic div_first;
		logic mul_init;
		logic mul_step;
		logic commit;
	} sgk_cmd_t;

	typedef struct packed {
		logic out_free;
	} sgk_status_t;

endpackage

FILE: rtl/sgk_ctrl.sv
// Controller state machine of the spike-gated scalar Kalman filter.
// Sequences gate, set-up, serial divide, serial multiply and write-back.
// Depends on sgk_pkg.
`timescale 1ns / 1ps

module sgk_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  sgk_pkg::sgk_status_t status,
	output sgk_pkg::sgk_cmd_t    cmd
);
	import sgk_pkg::*;

	localparam int CW = $clog2(FRAC_BITS + 2);
	localparam logic [CW-1:0] CNT_LAST = CW'(FRAC_BITS);

	sgk_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_GATE;
				end
			end
			ST_GATE: begin
				cmd.gate = 1'b1;
				state_d  = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				if (cnt_q == CNT_LAST) begin
					cnt_d   = '0;
					state_d = ST_MUL_LOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_MUL_LOAD: begin
				cmd.mul_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					cnt_d   = '0;
					state_d = ST_WB;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_WB: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/sgk_datapath.sv
// Datapath of the spike-gated scalar Kalman filter: registers, filter state,
// restoring divider, two shift-add multipliers and the output register.
// Depends on sgk_pkg; driven by sgk_ctrl.
`timescale 1ns / 1ps

module sgk_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sgk_pkg::ADDR_W-1:0]            cfg_addr,
	input  logic [sgk_pkg::REG_W-1:0]             cfg_data,
	input  logic [sgk_pkg::ANGLE_W-1:0]           sample_angle,
	input  sgk_pkg::sgk_cmd_t                     cmd,
	output sgk_pkg::sgk_status_t                  status,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [sgk_pkg::ANGLE_W-1:0]           angle_estimate,
	output logic                                  spike_replaced
);
	import sgk_pkg::*;

	localparam int KW  = FRAC_BITS + 1;
	localparam int A1W = EST_W + 2 + FRAC_BITS;
	localparam int A2W = COV_W + 1 + FRAC_BITS;
	localparam logic [63:0] ONE_FULL   = 64'd1 << FRAC_BITS;
	localparam logic [63:0] SPIKE_FULL = ONE_FULL * 64'd5;
	localparam logic [63:0] PREV_FULL  = (ONE_FULL * 64'd179) >> 1;
	localparam logic [REG_W-1:0] RST_NOISE = ONE_FULL[REG_W-1:0];
	localparam logic [REG_W-1:0] RST_SPIKE = SPIKE_FULL[REG_W-1:0];
	localparam logic [COV_W-1:0] RST_COV   = ONE_FULL[COV_W-1:0];
	localparam logic [EST_W-1:0] RST_PREV  = PREV_FULL[EST_W-1:0];
	localparam logic [KW-1:0]    ONE_K     = ONE_FULL[KW-1:0];
	localparam logic signed [EST_W+2:0] EST_MAX = 35'sd2147483647;
	localparam logic signed [EST_W+2:0] EST_MIN = -35'sd2147483648;

	logic [REG_W-1:0] proc_q, meas_q, spike_q;
	logic signed [EST_W-1:0] est_q, prev_q;
	logic [COV_W-1:0] cov_q;

	logic signed [ANGLE_W-1:0] sample_q;
	logic signed [EST_W-1:0]   msel_q;
	logic                      repl_q;
	logic [COV_W-1:0]          p_q;
	logic signed [EST_W:0]     diff_q;
	logic [COV_W:0]            denom_q;
	logic                      dz_q;
	logic [COV_W:0]            rem_q;
	logic [KW-1:0]             quo_q;
	logic [KW-1:0]             kmul_q, om_q;
	logic signed [A1W-1:0]     acc1_q;
	logic [A2W-1:0]            acc2_q;

	logic                    out_valid_q;
	logic [ANGLE_W-1:0]      filt_q;
	logic                    repl_out_q;

	logic signed [EST_W+1:0] gdiff;
	logic [EST_W+1:0]        gabs;
	logic                    grepl;
	logic [COV_W:0]          psum;
	logic [COV_W-1:0]        psat;
	logic [COV_W:0]          denom;
	logic [COV_W+1:0]        trial;
	logic                    ge;
	logic [KW-1:0]           kval;
	logic signed [EST_W+1:0] delta;
	logic signed [EST_W+2:0] xsum;
	logic signed [EST_W-1:0] xnew;
	logic [COV_W-1:0]        pnew;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_q  <= RST_NOISE;
			meas_q  <= RST_NOISE;
			spike_q <= RST_SPIKE;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PROCESS_NOISE:     proc_q  <= cfg_data;
				REG_MEASUREMENT_NOISE: meas_q  <= cfg_data;
				REG_SPIKE_LIMIT:       spike_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		gdiff = (EST_W+2)'(sample_q) - (EST_W+2)'(prev_q);
		gabs  = gdiff[EST_W+1] ? (EST_W+2)'(-gdiff) : (EST_W+2)'(gdiff);
		grepl = gabs > (EST_W+2)'(spike_q);
		psum  = (COV_W+1)'(cov_q) + (COV_W+1)'(proc_q);
		psat  = psum[COV_W] ? '1 : psum[COV_W-1:0];
		denom = (COV_W+1)'(p_q) + (COV_W+1)'(meas_q);
		trial = cmd.div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
		ge    = trial >= {1'b0, denom_q};
		kval  = dz_q ? '0 : quo_q;
		delta = acc1_q[A1W-1:FRAC_BITS];
		xsum  = (EST_W+3)'(est_q) + (EST_W+3)'(delta);
		if (xsum > EST_MAX) begin
			xnew = EST_MAX[EST_W-1:0];
		end else if (xsum < EST_MIN) begin
			xnew = EST_MIN[EST_W-1:0];
		end else begin
			xnew = xsum[EST_W-1:0];
		end
		pnew = acc2_q[FRAC_BITS +: COV_W];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample_angle;
		end
		if (cmd.gate) begin
			msel_q <= grepl ? prev_q : EST_W'(sample_q);
			repl_q <= grepl;
			p_q    <= psat;
		end
		if (cmd.prep) begin
			diff_q  <= (EST_W+1)'(msel_q) - (EST_W+1)'(est_q);
			denom_q <= denom;
			dz_q    <= (denom == '0);
			rem_q   <= (COV_W+1)'(p_q);
			quo_q   <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? (COV_W+1)'(trial - {1'b0, denom_q}) : trial[COV_W:0];
			quo_q <= {quo_q[KW-2:0], ge};
		end
		if (cmd.mul_init) begin
			kmul_q <= kval;
			om_q   <= ONE_K - kval;
			acc1_q <= '0;
			acc2_q <= '0;
		end
		if (cmd.mul_step) begin
			acc1_q <= (acc1_q <<< 1) + (kmul_q[KW-1] ? A1W'(diff_q) : A1W'(0));
			acc2_q <= (acc2_q << 1) + (om_q[KW-1] ? A2W'(p_q) : A2W'(0));
			kmul_q <= {kmul_q[KW-2:0], 1'b0};
			om_q   <= {om_q[KW-2:0], 1'b0};
		end
		if (cmd.commit) begin
			filt_q     <= xnew[ANGLE_W-1:0];
			repl_out_q <= repl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q       <= '0;
			prev_q      <= RST_PREV;
			cov_q       <= RST_COV;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				est_q  <= xnew;
				prev_q <= xnew;
				cov_q  <= pnew;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign angle_estimate  = filt_q;
	assign spike_replaced  = repl_out_q;

endmodule

FILE: rtl/spike_gated_scalar_kalman_top.sv
// Top level of the spike-gated scalar Kalman filter for a tilt angle.
// Joins the controller sgk_ctrl and the datapath sgk_datapath; depends on sgk_pkg.
//
// Usage: each input word on the slave stream carries one signed Q9.16 angle
// sample. A sample that jumps further than spike_limit from the previous
// estimate is swapped for that estimate, and a scalar Kalman update follows.
// Each input word yields exactly one output word: the new estimate on m_tdata
// and the replaced flag on m_tuser.
// Timing: one word is in work at a time. After acceptance the word passes the
// gate, set-up, divide, multiply-load, multiply and write-back states before
// m_tvalid rises; the bit-serial divider and the bit-serial multipliers each
// run FRAC_BITS+1 steps. A new word is taken only once the last is written back.
// The output register holds a finished word while the next sample is accepted
// and processed; if the receiver still stalls when that next result is ready,
// the block waits in write-back and s_tready stays low.
// Reset clears the estimate to 0, the covariance to 1.0, the previous estimate to
// 89.5 degrees, the registers to Q = R = 1.0 and spike limit 5.0. Registers are
// written by the user via cfg_we, cfg_addr, cfg_data only while idle; unchecked.
`timescale 1ns / 1ps

module spike_gated_scalar_kalman_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sgk_pkg::ADDR_W-1:0] cfg_addr,
	input  logic [sgk_pkg::REG_W-1:0]  cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,  // [24:0] sample_angle
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,  // [24:0] angle_estimate
	output logic                       m_tuser   // [0] spike_replaced
);
	import sgk_pkg::*;

	sgk_cmd_t           cmd;
	sgk_status_t        status;
	logic [ANGLE_W-1:0] filtered;

	sgk_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sgk_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_data       (cfg_data),
		.sample_angle   (s_tdata[ANGLE_W-1:0]),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.angle_estimate (filtered),
		.spike_replaced (m_tuser)
	);

	assign m_tdata = {{(32 - ANGLE_W){1'b0}}, filtered};

endmodule

FILE: test/spike_gated_scalar_kalman_top_tb.sv
// Testbench for spike_gated_scalar_kalman_top: drives angle words, predicts each filtered word.
// A built-in predictor follows the spike gate and the Kalman update under every register setting.
// Depends on sgk_pkg and the RTL of spike_gated_scalar_kalman_top only.
`timescale 1ns / 1ps

module spike_gated_scalar_kalman_top_tb;
	import sgk_pkg::*;

	localparam int FRAC = 16;
	localparam longint ANGLE_MAX = 64'sd11796480;
	localparam longint COV_MAX = 64'sd33554431;
	localparam longint ONE = 64'sd1 << FRAC;
	localparam logic [ADDR_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_WORDS = 1700;
	localparam int BURST_WORDS = 300;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               replaced;
	} kalman_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ADDR_W-1:0] cfg_addr;
	logic [REG_W-1:0]  cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [31:0]       m_tdata;
	logic              m_tuser;

	logic [REG_W-1:0]        q_reg;
	logic [REG_W-1:0]        r_reg;
	logic [REG_W-1:0]        lim_reg;
	logic signed [EST_W-1:0] kf_est;
	logic [COV_W-1:0]        kf_cov;
	logic signed [EST_W-1:0] kf_prev;

	kalman_word_t expected_words[$];
	bit tx_idle_en;
	bit rx_stall_en;
	int errors;
	int words_sent;
	int words_checked;
	int spikes_seen;
	int settings_used;
	int cycles;

	spike_gated_scalar_kalman_top #(
		.FRAC_BITS(FRAC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	function automatic kalman_word_t predict_kalman_step(input logic signed [ANGLE_W-1:0] angle);
		longint meas, diff, p, denom, gain, x;
		kalman_word_t w;
		meas = angle;
		diff = meas - longint'(kf_prev);
		if (diff < 0) diff = -diff;
		w.replaced = 1'b0;
		if (diff > longint'(lim_reg)) begin
			meas = kf_prev;
			w.replaced = 1'b1;
		end
		p = longint'(kf_cov) + longint'(q_reg);
		if (p > COV_MAX) p = COV_MAX;
		denom = p + longint'(r_reg);
		if (denom == 0) begin
			gain = 0;
		end else begin
			gain = (p <<< FRAC) / denom;
			if (gain > ONE) gain = ONE;
		end
		x = longint'(kf_est) + ((gain * (meas - longint'(kf_est))) >>> FRAC);
		if (x > 64'sd2147483647) x = 64'sd2147483647;
		if (x < -64'sd2147483648) x = -64'sd2147483648;
		kf_est = x[EST_W-1:0];
		kf_cov = COV_W'(((p * (ONE - gain)) >>> FRAC) & COV_MAX);
		kf_prev = kf_est;
		w.angle = x[ANGLE_W-1:0];
		return w;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] clamp_angle(input longint v);
		if (v > ANGLE_MAX) v = ANGLE_MAX;
		if (v < -ANGLE_MAX) v = -ANGLE_MAX;
		return v[ANGLE_W-1:0];
	endfunction

	function automatic logic signed [ANGLE_W-1:0] pick_angle();
		longint span, off;
		logic signed [ANGLE_W-1:0] raw;
		int sel;
		sel = $urandom_range(99);
		span = longint'(lim_reg) + longint'(lim_reg) / 2 + 2;
		if (sel < 60) begin
			off = longint'($urandom_range(0, 32'(2 * span))) - span;
			return clamp_angle(longint'(kf_prev) + off);
		end else if (sel < 70) begin
			off = longint'(lim_reg) + longint'($urandom_range(1));
			return clamp_angle(longint'(kf_prev) + ($urandom_range(1) ? off : -off));
		end else if (sel < 95) begin
			return clamp_angle(longint'($urandom_range(0, 32'(2 * ANGLE_MAX))) - ANGLE_MAX);
		end
		raw = ANGLE_W'($urandom());
		return raw;
	endfunction

	function automatic logic [REG_W-1:0] pick_noise();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return REG_W'($urandom_range(1, 4096));
			3: return REG_W'($urandom_range(16384, 262144));
			default: return REG_W'($urandom());
		endcase
	endfunction

	function automatic logic [REG_W-1:0] pick_limit();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return REG_W'($urandom_range(0, 65536));
			3, 4: return REG_W'($urandom_range(65536, 20 * 65536));
			default: return REG_W'($urandom());
		endcase
	endfunction

	task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
		kalman_word_t w;
		if (tx_idle_en && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 45)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, angle};
		do @(posedge clk); while (!s_tready);
		w = predict_kalman_step(angle);
		expected_words.push_back(w);
		words_sent++;
		if (w.replaced) spikes_seen++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_config(input logic [REG_W-1:0] q, input logic [REG_W-1:0] r,
			input logic [REG_W-1:0] lim, input bit poke_unused);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_addr <= REG_PROCESS_NOISE;
		cfg_data <= q;
		q_reg = q;
		@(negedge clk);
		cfg_addr <= REG_MEASUREMENT_NOISE;
		cfg_data <= r;
		r_reg = r;
		@(negedge clk);
		cfg_addr <= REG_SPIKE_LIMIT;
		cfg_data <= lim;
		lim_reg = lim;
		@(negedge clk);
		if (poke_unused) begin
			cfg_addr <= REG_UNUSED;
			cfg_data <= REG_W'($urandom());
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic test_directed_edges();
		send_angle('0);
		send_angle(clamp_angle(ANGLE_MAX));
		send_angle(clamp_angle(-ANGLE_MAX));
		send_angle(25'sh0FFFFFF);
		send_angle(25'sh1000000);
		send_angle(clamp_angle(longint'(kf_prev) + longint'(lim_reg)));
		send_angle(clamp_angle(longint'(kf_prev) - longint'(lim_reg)));
		send_angle(clamp_angle(longint'(kf_prev) + longint'(lim_reg) + 1));
		send_angle(clamp_angle(longint'(kf_prev) - longint'(lim_reg) - 1));
		send_angle(kf_prev[ANGLE_W-1:0]);
	endtask

	task automatic test_noise_extremes();
		apply_config('0, '0, '1, 1'b0);
		repeat (3) send_angle(pick_angle());
		apply_config('1, '1, '0, 1'b0);
		send_angle(kf_prev[ANGLE_W-1:0]);
		send_angle(clamp_angle(longint'(kf_prev) + 1));
		send_angle(clamp_angle(-ANGLE_MAX));
		apply_config('1, '0, REG_W'(5 * 65536), 1'b0);
		repeat (2) send_angle(pick_angle());
		apply_config('0, '1, '1, 1'b0);
		send_angle(clamp_angle(ANGLE_MAX));
		send_angle(clamp_angle(-ANGLE_MAX));
	endtask

	task automatic test_unused_register();
		apply_config(REG_W'(65536), REG_W'(4 * 65536), REG_W'(10 * 65536), 1'b1);
		repeat (4) send_angle(pick_angle());
	endtask

	task automatic test_random_tracking();
		int done;
		int phase_len;
		done = 0;
		while (done < RANDOM_WORDS) begin
			apply_config(pick_noise(), pick_noise(), pick_limit(), $urandom_range(3) == 0);
			tx_idle_en = $urandom_range(4) != 0;
			rx_stall_en = $urandom_range(4) != 0;
			phase_len = $urandom_range(50, 250);
			repeat (phase_len) send_angle(pick_angle());
			done += phase_len;
		end
	endtask

	task automatic test_back_to_back();
		apply_config(REG_W'(2048), REG_W'(65536), REG_W'(3 * 65536), 1'b0);
		tx_idle_en = 1'b0;
		rx_stall_en = 1'b0;
		repeat (BURST_WORDS) send_angle(pick_angle());
		tx_idle_en = 1'b1;
		rx_stall_en = 1'b1;
	endtask

	always @(negedge clk) begin
		m_tready <= rx_stall_en ? ($urandom_range(99) >= 35) : 1'b1;
	end

	always @(posedge clk) begin : check_words
		kalman_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("Output word with none expected: tdata %h tuser %b", m_tdata, m_tuser);
				errors++;
			end else begin
				w = expected_words.pop_front();
				if (m_tdata[ANGLE_W-1:0] !== w.angle) begin
					$error("angle_estimate: expected %0d, actual %0d",
						$signed(w.angle), $signed(m_tdata[ANGLE_W-1:0]));
					errors++;
				end
				if (m_tuser !== w.replaced) begin
					$error("spike_replaced: expected %0b, actual %0b", w.replaced, m_tuser);
					errors++;
				end
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words outstanding.",
				cycles, expected_words.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		tx_idle_en = 1'b1;
		rx_stall_en = 1'b1;
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		spikes_seen = 0;
		settings_used = 1;
		cycles = 0;
		q_reg = REG_W'(65536);
		r_reg = REG_W'(65536);
		lim_reg = REG_W'(5 * 65536);
		kf_est = '0;
		kf_cov = COV_W'(65536);
		kf_prev = EST_W'(5865472);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_edges();
		test_noise_extremes();
		test_unused_register();
		test_random_tracking();
		test_back_to_back();
		wait_idle();
		repeat (40) @(posedge clk);
		$display("Sent %0d angle words, checked %0d, %0d of them spike-gated.",
			words_sent, words_checked, spikes_seen);
		$display("Ran %0d register settings, zero and full-scale noise and limits among them.",
			settings_used);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/sgk_pkg.sv
rtl/sgk_ctrl.sv
rtl/sgk_datapath.sv
rtl/spike_gated_scalar_kalman_top.sv
test/spike_gated_scalar_kalman_top_tb.sv
